// ===== rtl/core/rrlbs_pkg.sv =====
`timescale 1ns / 1ps

package rrlbs_pkg;

    // Width of the hold counter and of both timing registers.
    localparam int unsigned HOLD_BITS = 10;

    // Input word widths.
    localparam int unsigned MODE_BITS  = 2;
    localparam int unsigned INDEX_BITS = 4;
    localparam int unsigned TIMES_BITS = 8;

    // Output word widths.
    localparam int unsigned LEVEL_OUT_BITS = 3;
    localparam int unsigned LED_OUT_BITS   = 2;

    // Reset values of the timing registers.
    localparam logic [HOLD_BITS-1:0] SHORT_HOLD_RESET  = 10'd10;
    localparam logic [HOLD_BITS-1:0] BLINK_PHASE_RESET = 10'd300;

    // Configuration register indexes.
    localparam logic CFG_SHORT_HOLD  = 1'b0;
    localparam logic CFG_BLINK_PHASE = 1'b1;

    // Kind of input word.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_TICK      = 2'd0,
        MODE_SET_OFF   = 2'd1,
        MODE_SET_ON    = 2'd2,
        MODE_SET_BLINK = 2'd3
    } t_item_mode;

    // What the sequencer does with one LED.
    typedef enum logic [1:0] {
        LED_OFF         = 2'd0,
        LED_ON          = 2'd1,
        LED_BLINK_START = 2'd2,
        LED_BLINKING    = 2'd3
    } t_led_mode;

    // Control of one accepted word, from the handshake side to the engine.
    typedef struct packed {
        logic                  fire;
        t_item_mode            mode;
        logic [INDEX_BITS-1:0] led_index;
    } t_item_ctl;

endpackage

// ===== rtl/core/rrlbs_engine.sv =====
`timescale 1ns / 1ps

module rrlbs_engine
    import rrlbs_pkg::*;
#(
    parameter int unsigned NUM_LEDS   = 3,
    parameter int unsigned COUNT_BITS = 8,
    localparam int unsigned CUR_BITS  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_item_ctl             i_ctl,
    input  logic [TIMES_BITS-1:0] i_blink_times,
    input  logic [HOLD_BITS-1:0]  i_short_hold,
    input  logic [HOLD_BITS-1:0]  i_blink_phase,
    output logic [NUM_LEDS-1:0]   o_next_levels,
    output logic [CUR_BITS-1:0]   o_next_led,
    output logic                  o_next_rejected
);

    // Blink count as stored: kept to COUNT_BITS bits.
    localparam int unsigned TIMES_KEEP = (COUNT_BITS < TIMES_BITS) ? COUNT_BITS : TIMES_BITS;

    t_led_mode             r_led_mode   [NUM_LEDS];
    logic [COUNT_BITS-1:0] r_target     [NUM_LEDS];
    logic [COUNT_BITS-1:0] r_left       [NUM_LEDS];
    logic [NUM_LEDS-1:0]   r_phase_on;
    logic [CUR_BITS-1:0]   r_cur;
    logic [HOLD_BITS-1:0]  r_hold;
    logic [NUM_LEDS-1:0]   r_levels;

    t_led_mode             n_led_mode   [NUM_LEDS];
    logic [COUNT_BITS-1:0] n_target     [NUM_LEDS];
    logic [COUNT_BITS-1:0] n_left       [NUM_LEDS];
    logic [NUM_LEDS-1:0]   n_phase_on;
    logic [CUR_BITS-1:0]   n_cur;
    logic [HOLD_BITS-1:0]  n_hold;
    logic [NUM_LEDS-1:0]   n_levels;
    logic                  n_rejected;

    logic [COUNT_BITS-1:0] times;
    logic [CUR_BITS-1:0]   cmd_led;
    logic                  out_of_range;
    logic                  advance;

    assign times        = COUNT_BITS'(i_blink_times[TIMES_KEEP-1:0]);
    assign cmd_led      = i_ctl.led_index[CUR_BITS-1:0];
    assign out_of_range = {1'b0, i_ctl.led_index} >= (INDEX_BITS + 1)'(NUM_LEDS);

    // Next state: a tick runs the sequencer; a command sets a mode or is rejected.
    always_comb begin
        n_led_mode = r_led_mode;
        n_target   = r_target;
        n_left     = r_left;
        n_phase_on = r_phase_on;
        n_cur      = r_cur;
        n_hold     = r_hold;
        n_levels   = r_levels;
        n_rejected = 1'b0;
        advance    = 1'b0;

        if (i_ctl.mode == MODE_TICK) begin
            if (n_hold != '0) begin
                n_hold = n_hold - 1'b1;
            end
            // Serve the current LED once the hold has run out.
            if (n_hold == '0) begin
                unique case (r_led_mode[r_cur])
                    LED_OFF: begin
                        n_levels[r_cur] = 1'b0;
                        n_hold          = i_short_hold;
                        advance         = 1'b1;
                    end
                    LED_ON: begin
                        n_levels[r_cur] = 1'b1;
                        n_hold          = i_short_hold;
                        advance         = 1'b1;
                    end
                    LED_BLINK_START: begin
                        if (r_target[r_cur] == '0) begin
                            n_levels[r_cur] = 1'b0;
                            n_hold          = i_short_hold;
                            advance         = 1'b1;
                        end else begin
                            n_led_mode[r_cur] = LED_BLINKING;
                            n_left[r_cur]     = r_target[r_cur];
                            n_phase_on[r_cur] = 1'b1;
                            n_levels[r_cur]   = 1'b1;
                            n_hold            = i_blink_phase;
                        end
                    end
                    LED_BLINKING: begin
                        if (!r_phase_on[r_cur]) begin
                            n_phase_on[r_cur] = 1'b1;
                            n_levels[r_cur]   = 1'b1;
                        end else begin
                            n_phase_on[r_cur] = 1'b0;
                            n_levels[r_cur]   = 1'b0;
                            // The off phase of the last blink ends the blink.
                            if (r_left[r_cur] <= COUNT_BITS'(1)) begin
                                n_left[r_cur]     = '0;
                                n_led_mode[r_cur] = LED_BLINK_START;
                                advance           = 1'b1;
                            end else begin
                                n_left[r_cur] = r_left[r_cur] - 1'b1;
                            end
                        end
                        n_hold = i_blink_phase;
                    end
                    default: begin
                        n_hold = i_short_hold;
                    end
                endcase
                if (advance) begin
                    n_cur = (r_cur == CUR_BITS'(NUM_LEDS - 1)) ? '0 : r_cur + 1'b1;
                end
            end
        end else if (out_of_range) begin
            n_rejected = 1'b1;
        end else begin
            case (i_ctl.mode)
                MODE_SET_OFF: begin
                    n_led_mode[cmd_led] = LED_OFF;
                    n_phase_on[cmd_led] = 1'b0;
                    n_target[cmd_led]   = '0;
                end
                MODE_SET_ON: begin
                    n_led_mode[cmd_led] = LED_ON;
                    n_phase_on[cmd_led] = 1'b1;
                    n_target[cmd_led]   = '0;
                end
                default: begin
                    n_led_mode[cmd_led] = LED_BLINK_START;
                    n_phase_on[cmd_led] = 1'b0;
                    n_target[cmd_led]   = times;
                end
            endcase
        end
    end

    // Sequencer state register, updated on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_led_mode[i] <= LED_OFF;
                r_target[i]   <= '0;
                r_left[i]     <= '0;
            end
            r_phase_on <= '0;
            r_cur      <= '0;
            r_hold     <= '0;
            r_levels   <= '0;
        end else if (i_ctl.fire) begin
            r_led_mode <= n_led_mode;
            r_target   <= n_target;
            r_left     <= n_left;
            r_phase_on <= n_phase_on;
            r_cur      <= n_cur;
            r_hold     <= n_hold;
            r_levels   <= n_levels;
        end
    end

    assign o_next_levels   = n_levels;
    assign o_next_led      = n_cur;
    assign o_next_rejected = n_rejected;

endmodule

// ===== rtl/core/round_robin_led_blink_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_mode, i_led_index, i_blink_times
// result    out        o_valid / i_ready  o_led_levels, o_serving_led, o_command_rejected
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// One word is accepted every cycle unless the result register stalls; its result is
// registered and shows in the next cycle; the sequencer state register updates per word.
// Reset is synchronous: all LEDs off, LED 0 served first, timing registers at defaults.
// While a result waits, a new word is taken only in the cycle the result is taken.

module round_robin_led_blink_sequencer_unit
    import rrlbs_pkg::*;
#(
    parameter int unsigned NUM_LEDS   = 3,
    parameter int unsigned COUNT_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [MODE_BITS-1:0]      i_mode,
    input  logic [INDEX_BITS-1:0]     i_led_index,
    input  logic [TIMES_BITS-1:0]     i_blink_times,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [LEVEL_OUT_BITS-1:0] o_led_levels,
    output logic [LED_OUT_BITS-1:0]   o_serving_led,
    output logic                      o_command_rejected,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [HOLD_BITS-1:0]      i_cfg_data
);

    localparam int unsigned CUR_BITS = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

    logic [HOLD_BITS-1:0]      r_short_hold;
    logic [HOLD_BITS-1:0]      r_blink_phase;
    logic                      r_valid;
    logic [LEVEL_OUT_BITS-1:0] r_levels;
    logic [LED_OUT_BITS-1:0]   r_led;
    logic                      r_rejected;

    t_item_ctl                   ctl;
    logic [NUM_LEDS-1:0]         next_levels;
    logic [CUR_BITS-1:0]         next_led;
    logic                        next_rejected;
    logic [NUM_LEDS+LEVEL_OUT_BITS-1:0] levels_ext;
    logic [CUR_BITS+LED_OUT_BITS-1:0]   led_ext;

    // The output register is free, or is emptied in this cycle.
    assign o_ready = !r_valid || i_ready;

    assign ctl.fire      = i_valid && o_ready;
    assign ctl.mode      = t_item_mode'(i_mode);
    assign ctl.led_index = i_led_index;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_hold  <= SHORT_HOLD_RESET;
            r_blink_phase <= BLINK_PHASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SHORT_HOLD:  r_short_hold  <= i_cfg_data;
                default:         r_blink_phase <= i_cfg_data;
            endcase
        end
    end

    rrlbs_engine #(
        .NUM_LEDS   (NUM_LEDS),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_blink_times   (i_blink_times),
        .i_short_hold    (r_short_hold),
        .i_blink_phase   (r_blink_phase),
        .o_next_levels   (next_levels),
        .o_next_led      (next_led),
        .o_next_rejected (next_rejected)
    );

    // Fit the internal widths to the fixed output fields.
    assign levels_ext = {{LEVEL_OUT_BITS{1'b0}}, next_levels};
    assign led_ext    = {{LED_OUT_BITS{1'b0}}, next_led};

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ctl.fire) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.fire) begin
            r_levels   <= levels_ext[LEVEL_OUT_BITS-1:0];
            r_led      <= led_ext[LED_OUT_BITS-1:0];
            r_rejected <= next_rejected;
        end
    end

    assign o_valid            = r_valid;
    assign o_led_levels       = r_levels;
    assign o_serving_led      = r_led;
    assign o_command_rejected = r_rejected;

endmodule

// ===== rtl/core/rrlbs_checker.sv =====
`timescale 1ns / 1ps

module rrlbs_checker
    import rrlbs_pkg::*;
#(
    parameter int unsigned NUM_LEDS = 3
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic [MODE_BITS-1:0]      i_mode,
    input logic [INDEX_BITS-1:0]     i_led_index,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [LEVEL_OUT_BITS-1:0] o_led_levels,
    input logic [LED_OUT_BITS-1:0]   o_serving_led,
    input logic                      o_command_rejected
);

    // A stalled result word holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_led_levels)
            && $stable(o_serving_led) && $stable(o_command_rejected))
        else $error("stalled result changed");

    // Input is taken whenever the result register is free or being emptied.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow the result register");

    // Every accepted word gives a result in the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("accepted word gave no result");

    // The reject flag matches the word that caused it.
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_command_rejected ==
            $past(i_mode != MODE_TICK && {1'b0, i_led_index} >= (INDEX_BITS + 1)'(NUM_LEDS)))
        else $error("reject flag does not match the command");

    // The LED named in a valid result word always exists.
    a_led_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {{INDEX_BITS{1'b0}}, o_serving_led} < (INDEX_BITS + LED_OUT_BITS)'(NUM_LEDS))
        else $error("served LED out of range");

endmodule

bind round_robin_led_blink_sequencer_unit rrlbs_checker #(
    .NUM_LEDS (NUM_LEDS)
) u_rrlbs_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .i_mode             (i_mode),
    .i_led_index        (i_led_index),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_led_levels       (o_led_levels),
    .o_serving_led      (o_serving_led),
    .o_command_rejected (o_command_rejected)
);

// ===== test/tb_round_robin_led_blink_sequencer_unit.sv =====
`timescale 1ns / 1ps

module tb_round_robin_led_blink_sequencer_unit;
    import rrlbs_pkg::*;

    localparam int unsigned NUM_LEDS       = 3;
    localparam int unsigned COUNT_BITS     = 8;
    localparam int unsigned HOLD_OFF_LEN   = 200;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_PHASES  = 6;
    localparam int unsigned PHASE_WORDS    = 320;

    // One input word as it waits to be offered.
    typedef struct packed {
        t_item_mode            mode;
        logic [INDEX_BITS-1:0] idx;
        logic [TIMES_BITS-1:0] times;
    } t_cmd_word;

    // One result word as the block should deliver it.
    typedef struct packed {
        logic [LEVEL_OUT_BITS-1:0] levels;
        logic [LED_OUT_BITS-1:0]   led;
        logic                      rejected;
    } t_led_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [MODE_BITS-1:0]      i_mode = '0;
    logic [INDEX_BITS-1:0]     i_led_index = '0;
    logic [TIMES_BITS-1:0]     i_blink_times = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [LEVEL_OUT_BITS-1:0] o_led_levels;
    logic [LED_OUT_BITS-1:0]   o_serving_led;
    logic                      o_command_rejected;
    logic                      i_cfg_we = 1'b0;
    logic                      i_cfg_index = 1'b0;
    logic [HOLD_BITS-1:0]      i_cfg_data = '0;

    // Words still to be offered, and result words still to arrive.
    t_cmd_word cmd_q[$];
    t_led_word led_word_q[$];

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned n_err = 0;

    // Shadow copy of the sequencer state and its timing registers.
    logic [HOLD_BITS-1:0]      cfg_short;
    logic [HOLD_BITS-1:0]      cfg_blink;
    t_led_mode                 led_st [NUM_LEDS];
    logic [COUNT_BITS-1:0]     blink_tgt [NUM_LEDS];
    logic [COUNT_BITS-1:0]     blinks_rem [NUM_LEDS];
    logic                      phase_hi [NUM_LEDS];
    int unsigned               cur_led;
    logic [HOLD_BITS-1:0]      hold_cnt;
    logic [LEVEL_OUT_BITS-1:0] levels;

    round_robin_led_blink_sequencer_unit #(
        .NUM_LEDS   (NUM_LEDS),
        .COUNT_BITS (COUNT_BITS)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_mode             (i_mode),
        .i_led_index        (i_led_index),
        .i_blink_times      (i_blink_times),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_led_levels       (o_led_levels),
        .o_serving_led      (o_serving_led),
        .o_command_rejected (o_command_rejected),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one word to the shadow state and returns the result word it causes.
    function automatic t_led_word next_led_word(t_item_mode mode, logic [INDEX_BITS-1:0] idx,
                                                logic [TIMES_BITS-1:0] times);
        t_led_word   w;
        logic        adv;
        int unsigned n;
        w.rejected = 1'b0;
        if (mode == MODE_TICK) begin
            if (hold_cnt != 0) hold_cnt = hold_cnt - 1'b1;
            if (hold_cnt == 0) begin
                n = cur_led;
                adv = 1'b0;
                case (led_st[n])
                    LED_OFF: begin
                        levels[n] = 1'b0;
                        hold_cnt = cfg_short;
                        adv = 1'b1;
                    end
                    LED_ON: begin
                        levels[n] = 1'b1;
                        hold_cnt = cfg_short;
                        adv = 1'b1;
                    end
                    LED_BLINK_START: begin
                        if (blink_tgt[n] == 0) begin
                            levels[n] = 1'b0;
                            hold_cnt = cfg_short;
                            adv = 1'b1;
                        end else begin
                            led_st[n] = LED_BLINKING;
                            blinks_rem[n] = blink_tgt[n];
                            phase_hi[n] = 1'b1;
                            levels[n] = 1'b1;
                            hold_cnt = cfg_blink;
                        end
                    end
                    default: begin
                        if (!phase_hi[n]) begin
                            phase_hi[n] = 1'b1;
                            levels[n] = 1'b1;
                        end else begin
                            phase_hi[n] = 1'b0;
                            levels[n] = 1'b0;
                            // The last off phase ends the blink; the count never wraps.
                            if (blinks_rem[n] <= 1) begin
                                blinks_rem[n] = '0;
                                led_st[n] = LED_BLINK_START;
                                adv = 1'b1;
                            end else begin
                                blinks_rem[n] = blinks_rem[n] - 1'b1;
                            end
                        end
                        hold_cnt = cfg_blink;
                    end
                endcase
                if (adv) cur_led = (cur_led == NUM_LEDS - 1) ? 0 : cur_led + 1;
            end
        end else if (idx >= NUM_LEDS) begin
            w.rejected = 1'b1;
        end else begin
            case (mode)
                MODE_SET_OFF: begin
                    led_st[idx] = LED_OFF;
                    phase_hi[idx] = 1'b0;
                    blink_tgt[idx] = '0;
                end
                MODE_SET_ON: begin
                    led_st[idx] = LED_ON;
                    phase_hi[idx] = 1'b1;
                    blink_tgt[idx] = '0;
                end
                default: begin
                    led_st[idx] = LED_BLINK_START;
                    phase_hi[idx] = 1'b0;
                    blink_tgt[idx] = times;
                end
            endcase
        end
        w.levels = levels;
        w.led = LED_OUT_BITS'(cur_led);
        return w;
    endfunction

    // Driver: offers queued words and records the expected result of each accepted one.
    always @(posedge i_clk) begin
        t_cmd_word c;
        logic      take;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            take = i_valid && o_ready;
            if (take) begin
                led_word_q.push_back(next_led_word(t_item_mode'(i_mode), i_led_index,
                                                   i_blink_times));
            end
            if (i_valid && !take) begin
                // Hold the word until the block takes it.
            end else if (cmd_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                c = cmd_q.pop_front();
                i_valid <= 1'b1;
                i_mode <= c.mode;
                i_led_index <= c.idx;
                i_blink_times <= c.times;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result word against the oldest expectation and paces i_ready.
    always @(posedge i_clk) begin
        t_led_word want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (led_word_q.size() == 0) begin
                    $error("result word with nothing expected: levels %0h led %0d rej %0d",
                           o_led_levels, o_serving_led, o_command_rejected);
                    n_err++;
                end else begin
                    want = led_word_q.pop_front();
                    if (o_led_levels !== want.levels) begin
                        $error("led_levels: expected %0h, actual %0h", want.levels,
                               o_led_levels);
                        n_err++;
                    end
                    if (o_serving_led !== want.led) begin
                        $error("serving_led: expected %0d, actual %0d", want.led,
                               o_serving_led);
                        n_err++;
                    end
                    if (o_command_rejected !== want.rejected) begin
                        $error("command_rejected: expected %0d, actual %0d", want.rejected,
                               o_command_rejected);
                        n_err++;
                    end
                end
            end
            // A long hold-off lets the result register fill and the input stall.
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    // Count cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("[round_robin_led_blink_sequencer_unit] ERROR");
        $finish;
    end

    task automatic queue_cmd(input t_item_mode mode, input logic [INDEX_BITS-1:0] idx,
                             input logic [TIMES_BITS-1:0] times);
        cmd_q.push_back('{mode: mode, idx: idx, times: times});
    endtask

    task automatic write_cfg(input logic idx, input logic [HOLD_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SHORT_HOLD) cfg_short = data;
        else cfg_blink = data;
    endtask

    // Wait until every word is offered, taken and answered.
    task automatic drain();
        @(negedge i_clk);
        while (cmd_q.size() != 0 || i_valid || led_word_q.size() != 0) @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin
        int unsigned r;
        t_item_mode  m;

        cfg_short = SHORT_HOLD_RESET;
        cfg_blink = BLINK_PHASE_RESET;
        for (int i = 0; i < NUM_LEDS; i++) begin
            led_st[i] = LED_OFF;
            blink_tgt[i] = '0;
            blinks_rem[i] = '0;
            phase_hi[i] = 1'b0;
        end
        cur_led = 0;
        hold_cnt = '0;
        levels = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset timing: first tick, every command, rejected indexes.
        queue_cmd(MODE_TICK, 4'd0, 8'd0);
        queue_cmd(MODE_SET_ON, 4'd0, 8'd0);
        queue_cmd(MODE_SET_BLINK, 4'd1, 8'd2);
        queue_cmd(MODE_SET_BLINK, 4'd2, 8'd0);
        queue_cmd(MODE_SET_OFF, 4'd3, 8'd0);
        queue_cmd(MODE_SET_BLINK, 4'd15, 8'd255);
        queue_cmd(MODE_SET_ON, 4'd8, 8'd0);
        queue_cmd(MODE_TICK, 4'd15, 8'd255);
        queue_cmd(MODE_TICK, 4'd0, 8'd0);
        drain();

        // Zero hold and the shortest blink phase: blinks, a replaced blink, maximum count.
        write_cfg(CFG_SHORT_HOLD, 10'd0);
        write_cfg(CFG_BLINK_PHASE, 10'd1);
        queue_cmd(MODE_SET_BLINK, 4'd0, 8'd1);
        queue_cmd(MODE_SET_BLINK, 4'd1, 8'd3);
        repeat (8) queue_cmd(MODE_TICK, 4'd0, 8'd0);
        queue_cmd(MODE_SET_ON, 4'd1, 8'd0);
        repeat (4) queue_cmd(MODE_TICK, 4'd0, 8'd0);
        queue_cmd(MODE_SET_BLINK, 4'd2, 8'd255);
        queue_cmd(MODE_TICK, 4'd0, 8'd0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin write_cfg(CFG_SHORT_HOLD, 10'd10); write_cfg(CFG_BLINK_PHASE, 10'd300); end
                1: begin write_cfg(CFG_SHORT_HOLD, 10'd1023); write_cfg(CFG_BLINK_PHASE, 10'd2); end
                2: begin write_cfg(CFG_SHORT_HOLD, 10'd1); write_cfg(CFG_BLINK_PHASE, 10'd1023); end
                3: begin
                    write_cfg(CFG_SHORT_HOLD, 10'($urandom_range(1, 15)));
                    write_cfg(CFG_BLINK_PHASE, 10'($urandom_range(1, 15)));
                end
                4: begin
                    write_cfg(CFG_SHORT_HOLD, 10'd3);
                    write_cfg(CFG_BLINK_PHASE, 10'($urandom_range(0, 7)));
                end
                default: begin
                    write_cfg(CFG_SHORT_HOLD, 10'($urandom_range(0, 1023)));
                    write_cfg(CFG_BLINK_PHASE, 10'($urandom_range(0, 1023)));
                end
            endcase
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 62; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 62; end
                default: begin src_idle_pct = 36; snk_stall_pct = 36; end
            endcase

            // Mostly ticks with commands to real LEDs; a few noise words.
            for (int k = 0; k < PHASE_WORDS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    queue_cmd(MODE_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                end else if (r < 95) begin
                    m = t_item_mode'($urandom_range(1, 3));
                    queue_cmd(m, 4'($urandom_range(0, NUM_LEDS - 1)),
                              ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 4)));
                end else begin
                    queue_cmd(t_item_mode'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                              8'($urandom_range(0, 255)));
                end
            end
            if (p == 4) hold_req = hold_req + 1;
            drain();
        end

        src_idle_pct = 0;
        snk_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        if (n_err == 0) begin
            $display("[round_robin_led_blink_sequencer_unit] OK");
        end else begin
            $display("[round_robin_led_blink_sequencer_unit] ERROR");
        end
        $finish;
    end

endmodule
